// ----- hw/rtl/ccfr_pkg.sv -----
// Shared types, codes and the CRC-32 byte update for the frame receiver.
package ccfr_pkg;

    localparam logic [2:0] PH_OPCODE  = 3'd0;
    localparam logic [2:0] PH_ADDRESS = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CRC     = 3'd4;

    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_TIMEOUT = 1'b1;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    localparam logic [1:0] ST_OK_CHECKED   = 2'd0;
    localparam logic [1:0] ST_OK_UNCHECKED = 2'd1;
    localparam logic [1:0] ST_CRC_ERROR    = 2'd2;
    localparam logic [1:0] ST_TIMEOUT      = 2'd3;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  opcode;
        logic [15:0] frame_address;
        logic [15:0] payload_length;
        logic [1:0]  frame_status;
        logic [31:0] computed_crc;
    } result_t;

    // Reflected CRC-32 update over one byte, least significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ----- hw/rtl/ccfr_parse.sv -----
// Frame parser: phase tracking, header capture, running CRC and result build.
module ccfr_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              mode,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output ccfr_pkg::result_t res
);

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [15:0] address_reg, address_next;
    logic [15:0] length_reg, length_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rx_crc_reg, rx_crc_next;

    logic [31:0] crc_final;
    logic [31:0] crc_updated;
    logic [15:0] count_inc;
    logic [31:0] rx_crc_full;

    assign crc_final   = crc_reg ^ ccfr_pkg::CRC_ONES;
    assign crc_updated = ccfr_pkg::crc_byte(crc_reg, rx_byte);
    assign count_inc   = count_reg + 16'd1;
    assign rx_crc_full = rx_crc_reg | ({24'd0, rx_byte} << {count_reg[1:0], 3'b000});

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        opcode_next  = opcode_reg;
        address_next = address_reg;
        length_next  = length_reg;
        crc_next     = crc_reg;
        rx_crc_next  = rx_crc_reg;
        res_valid    = 1'b0;
        res.kind          = ccfr_pkg::KIND_FRAME;
        res.payload_byte  = 8'd0;
        res.payload_index = 16'd0;
        res.frame_status  = ccfr_pkg::ST_OK_CHECKED;
        res.computed_crc  = 32'd0;

        if (mode == ccfr_pkg::MODE_TIMEOUT) begin
            if (phase_reg != ccfr_pkg::PH_OPCODE) begin
                res_valid        = 1'b1;
                res.frame_status = ccfr_pkg::ST_TIMEOUT;
                res.computed_crc = crc_final;
                phase_next       = ccfr_pkg::PH_OPCODE;
                count_next       = 16'd0;
            end
        end else begin
            case (phase_reg)
                ccfr_pkg::PH_OPCODE: begin
                    opcode_next  = rx_byte;
                    address_next = 16'd0;
                    length_next  = 16'd0;
                    rx_crc_next  = 32'd0;
                    crc_next     = ccfr_pkg::CRC_ONES;
                    count_next   = 16'd0;
                    phase_next   = ccfr_pkg::PH_ADDRESS;
                end
                ccfr_pkg::PH_ADDRESS: begin
                    if (count_reg == 16'd0) begin
                        address_next = {8'd0, rx_byte};
                        count_next   = 16'd1;
                    end else begin
                        address_next = {rx_byte, address_reg[7:0]};
                        count_next   = 16'd0;
                        phase_next   = ccfr_pkg::PH_LENGTH;
                    end
                end
                ccfr_pkg::PH_LENGTH: begin
                    if (count_reg == 16'd0) begin
                        length_next = {8'd0, rx_byte};
                        count_next  = 16'd1;
                    end else begin
                        length_next = {rx_byte, length_reg[7:0]};
                        count_next  = 16'd0;
                        if (length_next == 16'd0) begin
                            res_valid        = 1'b1;
                            res.frame_status = ccfr_pkg::ST_OK_UNCHECKED;
                            res.computed_crc = crc_final;
                            phase_next       = ccfr_pkg::PH_OPCODE;
                        end else begin
                            phase_next = ccfr_pkg::PH_PAYLOAD;
                        end
                    end
                end
                ccfr_pkg::PH_PAYLOAD: begin
                    crc_next          = crc_updated;
                    res_valid         = 1'b1;
                    res.kind          = ccfr_pkg::KIND_BYTE;
                    res.payload_byte  = rx_byte;
                    res.payload_index = count_reg;
                    if (count_inc == length_reg) begin
                        count_next = 16'd0;
                        phase_next = ccfr_pkg::PH_CRC;
                    end else begin
                        count_next = count_inc;
                    end
                end
                ccfr_pkg::PH_CRC: begin
                    rx_crc_next = rx_crc_full;
                    count_next  = count_inc;
                    // The fourth byte completes the received CRC and ends the frame.
                    if (count_reg[1:0] == 2'd3) begin
                        res_valid        = 1'b1;
                        res.computed_crc = crc_final;
                        if (rx_crc_full == 32'd0) begin
                            res.frame_status = ccfr_pkg::ST_OK_UNCHECKED;
                        end else if (rx_crc_full == crc_final) begin
                            res.frame_status = ccfr_pkg::ST_OK_CHECKED;
                        end else begin
                            res.frame_status = ccfr_pkg::ST_CRC_ERROR;
                        end
                        phase_next = ccfr_pkg::PH_OPCODE;
                        count_next = 16'd0;
                    end
                end
                default: begin
                    phase_next = ccfr_pkg::PH_OPCODE;
                    count_next = 16'd0;
                end
            endcase
        end

        res.opcode         = opcode_next;
        res.frame_address  = address_next;
        res.payload_length = length_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= ccfr_pkg::PH_OPCODE;
            count_reg   <= 16'd0;
            opcode_reg  <= 8'd0;
            address_reg <= 16'd0;
            length_reg  <= 16'd0;
            crc_reg     <= ccfr_pkg::CRC_ONES;
            rx_crc_reg  <= 32'd0;
        end else if (step) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            opcode_reg  <= opcode_next;
            address_reg <= address_next;
            length_reg  <= length_next;
            crc_reg     <= crc_next;
            rx_crc_reg  <= rx_crc_next;
        end
    end

endmodule

// ----- hw/rtl/crc_checked_frame_receiver.sv -----
// Top level: input register, frame parser and output register of the frame receiver.
// An accepted item waits in the input register; its result is registered onto m_.
// Throughput: one item per cycle unless m_ready stalls; the CRC byte update and
// header capture sit in the single logic stage between input and output registers.
// Reset: synchronous, active low; clears the valid flags of both register stages
// and returns the parser to waiting for an opcode with the running CRC at all ones.
module crc_checked_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_payload_index,
    output logic [7:0]  m_opcode,
    output logic [15:0] m_frame_address,
    output logic [15:0] m_payload_length,
    output logic [1:0]  m_frame_status,
    output logic [31:0] m_computed_crc
);

    logic              in_valid_reg;
    logic              in_mode_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    ccfr_pkg::result_t out_reg;

    logic              advance;
    logic              step;
    logic              res_valid;
    ccfr_pkg::result_t res;

    // The output register may load when it is empty or its item leaves now.
    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    ccfr_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .mode      (in_mode_reg),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_mode_reg <= s_mode;
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_payload_index  = out_reg.payload_index;
    assign m_opcode         = out_reg.opcode;
    assign m_frame_address  = out_reg.frame_address;
    assign m_payload_length = out_reg.payload_length;
    assign m_frame_status   = out_reg.frame_status;
    assign m_computed_crc   = out_reg.computed_crc;

    a_empty_input_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but s_ready low");

    a_stall_holds_item : assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(in_mode_reg))
        else $error("buffered item lost during output stall");

    a_byte_fields_clear : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == ccfr_pkg::KIND_BYTE |->
            m_frame_status == ccfr_pkg::ST_OK_CHECKED && m_computed_crc == 32'd0)
        else $error("forwarded byte carries status fields");

    a_zero_length_status : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == ccfr_pkg::KIND_FRAME && m_payload_length == 16'd0
            && m_frame_status != ccfr_pkg::ST_TIMEOUT |->
            m_frame_status == ccfr_pkg::ST_OK_UNCHECKED && m_computed_crc == 32'd0)
        else $error("zero-length frame reported with wrong status or CRC");

endmodule
